// ===== sv/fos_pkg.sv =====
// ----------------------------------------------------------------------------
// fos_pkg: shared types and codes of the fermion occupation string
// action, error and phase codes, beat structs and controller/datapath bundles
// ----------------------------------------------------------------------------
package fos_pkg;

	localparam int MAX_ORBITALS = 64;
	localparam int MASK_W       = 64;
	localparam int ORB_W        = 7;
	localparam int IDX_W        = 6;

	localparam logic [ORB_W-1:0] BASIS_RESET = 7'd64;
	localparam logic [ORB_W-1:0] ORB_LIMIT   = 7'(MAX_ORBITALS);

	// action codes
	localparam logic [1:0] ACT_CREATE  = 2'd0;
	localparam logic [1:0] ACT_DESTROY = 2'd1;
	localparam logic [1:0] ACT_NEXT    = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_ORBITAL = 2'd1;
	localparam logic [1:0] ERR_EMPTY   = 2'd2;

	// phase codes
	localparam logic signed [1:0] PH_ZERO = 2'sd0;
	localparam logic signed [1:0] PH_POS  = 2'sd1;
	localparam logic signed [1:0] PH_NEG  = -2'sd1;

	typedef struct packed {
		logic [1:0]       action;
		logic [ORB_W-1:0] orbital;
	} request_t;

	typedef struct packed {
		logic signed [1:0] phase;
		logic [1:0]        error;
		logic [MASK_W-1:0] occupancy;
		logic [ORB_W-1:0]  electron_count;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // latch request, arm the scan
		logic exec_op;   // finish create, destroy or unused action
		logic scan_step; // drop highest remaining orbital
		logic scan_hit;  // remember the orbital that moves
		logic scan_end;  // no orbital can move, finish unchanged
		logic build;     // write the next combination and finish
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_next;
		logic scan_empty;
		logic scan_fits;
	} dp_status_t;

endpackage

// ===== sv/fos_ctrl.sv =====
// ----------------------------------------------------------------------------
// fos_ctrl: controller of the fermion occupation string
// sequences one request through execute, scan and build, raises done
// ----------------------------------------------------------------------------
module fos_ctrl import fos_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t status,
	output dp_cmd_t    cmd,
	output logic       busy,
	output logic       done
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EXEC  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_BUILD = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (status.is_next) begin
					state_d = ST_SCAN;
				end else begin
					cmd.exec_op = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (status.scan_empty) begin
					cmd.scan_end = 1'b1;
					state_d      = ST_IDLE;
				end else if (status.scan_fits) begin
					cmd.scan_hit = 1'b1;
					state_d      = ST_BUILD;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_BUILD: begin
				cmd.build = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.exec_op | cmd.scan_end | cmd.build;
		end
	end

endmodule

// ===== sv/fos_datapath.sv =====
// ----------------------------------------------------------------------------
// fos_datapath: occupancy state and arithmetic of the fermion occupation string
// parity of masked occupancy, top-down scan for the next combination
// ----------------------------------------------------------------------------
module fos_datapath import fos_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  request_t         request,
	input  logic             cfg_we,
	input  logic [ORB_W-1:0] cfg_data,
	input  dp_cmd_t          cmd,
	output dp_status_t       status,
	output result_t          result
);

	logic [MASK_W-1:0] mask_q;
	logic [ORB_W-1:0]  count_q;
	logic [ORB_W-1:0]  basis_q;
	logic [1:0]        act_q;
	logic [ORB_W-1:0]  orb_q;
	logic [MASK_W-1:0] rem_q;
	logic [ORB_W-1:0]  tail_q;
	logic [IDX_W-1:0]  hit_q;
	result_t           res_q;

	logic [ORB_W-1:0]  lim;
	logic [IDX_W-1:0]  bit_idx;
	logic [MASK_W-1:0] bit_sel;
	logic [MASK_W-1:0] above;
	logic [MASK_W-1:0] below;
	logic              invalid;
	logic [MASK_W-1:0] op_mask;
	logic [ORB_W-1:0]  op_count;
	logic signed [1:0] op_phase;
	logic [1:0]        op_error;
	logic [IDX_W-1:0]  top_idx;
	logic [ORB_W-1:0]  tail_inc;
	logic [ORB_W-1:0]  hit_inc;
	logic [MASK_W-1:0] fill;
	logic [MASK_W-1:0] build_mask;

	assign lim = (basis_q > ORB_LIMIT) ? ORB_LIMIT : basis_q;

	// create and destroy
	always_comb begin
		bit_idx  = IDX_W'(orb_q - 7'd1);
		bit_sel  = {{(MASK_W-1){1'b0}}, 1'b1} << bit_idx;
		above    = {MASK_W{1'b1}} << orb_q;
		below    = bit_sel - {{(MASK_W-1){1'b0}}, 1'b1};
		invalid  = (orb_q == '0) || (orb_q > lim);
		op_mask  = mask_q;
		op_count = count_q;
		op_phase = PH_ZERO;
		op_error = ERR_NONE;
		if (act_q == ACT_CREATE || act_q == ACT_DESTROY) begin
			if (invalid) begin
				op_error = ERR_ORBITAL;
			end else if (act_q == ACT_CREATE) begin
				if ((mask_q & bit_sel) == '0) begin
					op_phase = ^(mask_q & above) ? PH_NEG : PH_POS;
					op_mask  = mask_q | bit_sel;
					op_count = count_q + 7'd1;
				end
			end else begin
				if (mask_q == '0) begin
					op_error = ERR_EMPTY;
				end else if ((mask_q & bit_sel) != '0) begin
					op_phase = ^(mask_q & below) ? PH_NEG : PH_POS;
					op_mask  = mask_q & ~bit_sel;
					op_count = count_q - 7'd1;
				end
			end
		end
	end

	// highest remaining occupied orbital
	always_comb begin
		top_idx = '0;
		for (int b = 0; b < MASK_W; b++) begin
			if (rem_q[b]) top_idx = IDX_W'(b);
		end
	end

	assign status.is_next    = (act_q == ACT_NEXT);
	assign status.scan_empty = (rem_q == '0);
	// orbital top_idx+1 moves up one, tail_q orbitals follow right above it
	assign status.scan_fits  = ({2'b00, top_idx} + {1'b0, tail_q} + 8'd2) <= {1'b0, lim};

	// keep orbitals below the moving one, then a run of tail+1 from one above it
	always_comb begin
		tail_inc   = tail_q + 7'd1;
		hit_inc    = {1'b0, hit_q} + 7'd1;
		fill       = ~({MASK_W{1'b1}} << tail_inc);
		build_mask = (mask_q & ((({{(MASK_W-1){1'b0}}, 1'b1}) << hit_q)
			- {{(MASK_W-1){1'b0}}, 1'b1})) | (fill << hit_inc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '0;
			count_q <= '0;
			basis_q <= BASIS_RESET;
		end else begin
			if (cfg_we) basis_q <= cfg_data;
			if (cmd.exec_op) begin
				mask_q  <= op_mask;
				count_q <= op_count;
			end else if (cmd.build) begin
				mask_q  <= build_mask;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= request.action;
			orb_q  <= request.orbital;
			rem_q  <= mask_q;
			tail_q <= '0;
		end else if (cmd.scan_step) begin
			rem_q  <= rem_q & ~({{(MASK_W-1){1'b0}}, 1'b1} << top_idx);
			tail_q <= tail_inc;
		end
		if (cmd.scan_hit) hit_q <= top_idx;
		if (cmd.exec_op) begin
			res_q.phase          <= op_phase;
			res_q.error          <= op_error;
			res_q.occupancy      <= op_mask;
			res_q.electron_count <= op_count;
		end else if (cmd.build) begin
			res_q.phase          <= PH_POS;
			res_q.error          <= ERR_NONE;
			res_q.occupancy      <= build_mask;
			res_q.electron_count <= count_q;
		end else if (cmd.scan_end) begin
			res_q.phase          <= PH_ZERO;
			res_q.error          <= ERR_NONE;
			res_q.occupancy      <= mask_q;
			res_q.electron_count <= count_q;
		end
	end

	assign result = res_q;

endmodule

// ===== sv/fermion_occupation_string_top.sv =====
// ----------------------------------------------------------------------------
// fermion_occupation_string_top: occupancy string of one determinant
// create, destroy and next-combination steps with fermion sign
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low. Create, destroy
// and the unused action code answer through the execute state: the beat is
// latched at the accepting edge, and the next edge updates the occupancy and
// raises done with the result beat, so a new request can be taken once done
// is high. Next walks the occupied orbitals from the top down, one orbital per
// cycle, until one of them can move up, then writes the new set from the build
// state and raises done; the orbitals passed over before the one that moves
// number at most the electron count less one. When no orbital can move, or the
// set is empty, the scan ends with the set unchanged and raises done. Done is
// high for a single cycle with the result beat and cannot be held off;
// a new request may be issued in that same cycle. basis_size is written
// through cfg_valid/cfg_data, always ready, and must only change while idle.
// The electron count is kept as a running counter beside the occupancy mask.
// ----------------------------------------------------------------------------
module fermion_occupation_string_top import fos_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  request_t         request,
	output logic             done,
	output result_t          result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [ORB_W-1:0] cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// config writes accepted any cycle
	assign cfg_ready = 1'b1;

	fos_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	fos_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.status   (status),
		.result   (result)
	);

	// a result only leaves once the controller is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// an accepted beat always starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	// running count tracks the mask
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($countones(result.occupancy) == 32'(result.electron_count)))
		else $error("electron count out of step with occupancy");

	// an error never carries a sign
	a_err_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.error != ERR_NONE) |-> (result.phase == PH_ZERO))
		else $error("error with nonzero phase");

endmodule

// ===== tb/fermion_occupation_string_top_test.sv =====
// ----------------------------------------------------------------------------
// fermion_occupation_string_top_test: self-checking bench for the occupancy string
// drives create, destroy and next-combination requests over several basis
// sizes, predicts sign, error and occupancy per beat, and checks each result
// ----------------------------------------------------------------------------
module fermion_occupation_string_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import fos_pkg::*;

	// action code 3 has no meaning in the block and must change nothing
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 800000;
	// next walks at most 64 orbitals before its result comes back
	localparam int unsigned SETTLE_CYCLES = 80;
	localparam int unsigned PHASE_ITEMS = 90;

	// expected-result store plus a private copy of the occupancy and basis size
	class occupancy_scoreboard;
		logic [MASK_W-1:0] occ_mask;
		logic [ORB_W-1:0]  basis;
		result_t           pending_results[$];
		int unsigned       mismatches;

		function new();
			occ_mask = '0;
			basis = BASIS_RESET;
			mismatches = 0;
		endfunction

		function void set_basis(logic [ORB_W-1:0] value);
			basis = value;
		endfunction

		function int unsigned orbital_limit();
			return (basis > MAX_ORBITALS) ? MAX_ORBITALS : basis;
		endfunction

		// lexicographic successor of the same size, 1 if the set moved
		function logic step_to_next_combination();
			int unsigned pos[MASK_W];
			int n;
			int i;
			int j;
			int tail;
			int lim;
			logic [MASK_W-1:0] m;
			n = 0;
			lim = orbital_limit();
			for (j = 0; j < MASK_W; j++) begin
				if (occ_mask[j]) begin
					pos[n] = j + 1;
					n++;
				end
			end
			for (i = n - 1; i >= 0; i--) begin
				tail = n - 1 - i;
				if (int'(pos[i]) + 1 <= lim - tail) begin
					m = '0;
					for (j = 0; j < i; j++)
						m[pos[j] - 1] = 1'b1;
					for (j = 0; j <= tail; j++)
						m[pos[i] + j] = 1'b1;
					occ_mask = m;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function result_t advance_string(request_t req);
			result_t res;
			int unsigned lim;
			int unsigned orb;
			logic [MASK_W-1:0] bit_mask;
			logic [MASK_W-1:0] passed;
			lim = orbital_limit();
			orb = req.orbital;
			res.phase = PH_ZERO;
			res.error = ERR_NONE;
			if (req.action == ACT_CREATE || req.action == ACT_DESTROY) begin
				if (orb == 0 || orb > lim) begin
					res.error = ERR_ORBITAL;
				end else begin
					bit_mask = 64'd1 << (orb - 1);
					if (req.action == ACT_CREATE) begin
						if ((occ_mask & bit_mask) == '0) begin
							// sign from the orbitals above the new one
							passed = (orb >= MASK_W) ? '0 : ({MASK_W{1'b1}} << orb);
							res.phase = ($countones(occ_mask & passed) % 2 == 1) ? PH_NEG : PH_POS;
							occ_mask |= bit_mask;
						end
					end else if (occ_mask == '0) begin
						res.error = ERR_EMPTY;
					end else if ((occ_mask & bit_mask) != '0) begin
						// sign from the orbitals below the removed one
						passed = bit_mask - 1;
						res.phase = ($countones(occ_mask & passed) % 2 == 1) ? PH_NEG : PH_POS;
						occ_mask &= ~bit_mask;
					end
				end
			end else if (req.action == ACT_NEXT) begin
				if (step_to_next_combination())
					res.phase = PH_POS;
			end
			res.occupancy = occ_mask;
			res.electron_count = ORB_W'($countones(occ_mask));
			return res;
		endfunction

		function void note_request(request_t req);
			pending_results.push_back(advance_string(req));
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing pending, occupancy %h",
					got.occupancy));
				return;
			end
			want = pending_results.pop_front();
			if (got.phase !== want.phase)
				report_mismatch($sformatf("phase got %b want %b", got.phase, want.phase));
			if (got.error !== want.error)
				report_mismatch($sformatf("error got %0d want %0d", got.error, want.error));
			if (got.occupancy !== want.occupancy)
				report_mismatch($sformatf("occupancy got %h want %h",
					got.occupancy, want.occupancy));
			if (got.electron_count !== want.electron_count)
				report_mismatch($sformatf("electron_count got %0d want %0d",
					got.electron_count, want.electron_count));
		endtask
	endclass

	logic              clk;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	request_t          request = '0;
	logic              done;
	result_t           result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [ORB_W-1:0]  cfg_data = '0;

	occupancy_scoreboard sb;
	// when set, pace never idles the sender between request beats
	bit                steady = 1'b0;
	int unsigned       cycle_count;

	fermion_occupation_string_top dut (
		.clk,
		.arst_n,
		.start,
		.busy,
		.request,
		.done,
		.result,
		.cfg_valid,
		.cfg_ready,
		.cfg_data
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// a result beat is taken at the edge that ends its done cycle
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_result(result);
	end

	// hard stop in case the block hangs
	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("[fermion_occupation_string_top] ERROR");
		$finish;
	end

	function automatic request_t make_req(logic [1:0] act, int unsigned orb);
		request_t r;
		r.action = act;
		r.orbital = orb[ORB_W-1:0];
		return r;
	endfunction

	// random occupied orbital, scanning up from a random bit
	function automatic int unsigned pick_occupied();
		int unsigned first;
		int unsigned b;
		int unsigned k;
		first = $urandom_range(0, MASK_W - 1);
		for (k = 0; k < MASK_W; k++) begin
			b = (first + k) % MASK_W;
			if (sb.occ_mask[b])
				return b + 1;
		end
		return 1;
	endfunction

	// mostly valid create/destroy/next, with some bad orbitals and the unused code
	function automatic request_t random_item();
		int unsigned lim;
		int unsigned roll;
		int unsigned orb;
		lim = sb.orbital_limit();
		roll = $urandom_range(0, 99);
		if (roll < 35)
			return make_req(ACT_CREATE, $urandom_range(1, lim));
		if (roll < 60) begin
			if (sb.occ_mask != '0 && $urandom_range(0, 9) < 6)
				orb = pick_occupied();
			else
				orb = $urandom_range(1, lim);
			return make_req(ACT_DESTROY, orb);
		end
		if (roll < 85)
			return make_req(ACT_NEXT, $urandom_range(0, 127));
		if (roll < 95) begin
			case ($urandom_range(0, 3))
				0: orb = 0;
				1: orb = lim + 1;
				2: orb = 127;
				default: orb = $urandom_range(lim + 1, 127);
			endcase
			return make_req($urandom_range(0, 1) ? ACT_CREATE : ACT_DESTROY, orb);
		end
		return make_req(ACT_UNUSED, $urandom_range(0, 127));
	endfunction

	// hold the beat until the block takes it; start stays high for the caller
	task automatic issue(request_t req);
		start <= 1'b1;
		request <= req;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_request(req);
	endtask

	// random sender idling, now and then long enough to outlast a next scan
	task automatic pace();
		int unsigned gap;
		if (!steady && $urandom_range(0, 99) < 29) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 75) : $urandom_range(1, 3);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic play(logic [1:0] act, int unsigned orb);
		issue(make_req(act, orb));
		pace();
	endtask

	// stop sending until every pending result has come back
	task automatic drain();
		if (start)
			start <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	// basis_size changes only with the block idle
	task automatic write_basis(int unsigned value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value[ORB_W-1:0];
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		sb.set_basis(value[ORB_W-1:0]);
	endtask

	// destroy every occupied orbital that the current limit lets through
	task automatic clear_string();
		int unsigned b;
		for (b = 0; b < sb.orbital_limit(); b++) begin
			if (sb.occ_mask[b])
				play(ACT_DESTROY, b + 1);
		end
	endtask

	task automatic run_phase(int unsigned items);
		int unsigned sent;
		int unsigned roll;
		int unsigned run;
		int unsigned lim;
		int unsigned o;
		sent = 0;
		while (sent < items) begin
			roll = $urandom_range(0, 99);
			lim = sb.orbital_limit();
			if (roll < 2) begin
				// create lim orbitals, each counted from the bottom or the top, so next can run out
				for (o = 1; o <= lim; o++)
					play(ACT_CREATE, $urandom_range(0, 1) ? o : lim + 1 - o);
				sent += lim;
			end else if (roll < 16) begin
				// walk a string of combinations
				run = $urandom_range(4, 20);
				repeat (run) play(ACT_NEXT, $urandom_range(0, 127));
				sent += run;
			end else begin
				issue(random_item());
				if ($urandom_range(0, 99) < 2)
					drain();
				else
					pace();
				sent++;
			end
		end
	endtask

	initial begin
		int unsigned plan[10];
		int unsigned p;
		plan = '{64, 1, 5, 64, 0, 8, 2, 64, 0, 3};
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// empty string: next does nothing, destroy reports empty,
		// but a bad orbital is caught before the empty check
		play(ACT_NEXT, 127);
		play(ACT_DESTROY, 5);
		play(ACT_DESTROY, 0);
		// orbital out of range at both ends and at the top of the field range
		play(ACT_CREATE, 0);
		play(ACT_CREATE, 65);
		play(ACT_CREATE, 127);
		// top and bottom orbitals, then a repeat create that is excluded
		play(ACT_CREATE, 64);
		play(ACT_CREATE, 1);
		play(ACT_CREATE, 1);
		play(ACT_CREATE, 32);
		// destroy of an absent orbital, unused action code
		play(ACT_DESTROY, 33);
		play(ACT_UNUSED, 127);
		play(ACT_DESTROY, 64);
		play(ACT_NEXT, 0);
		play(ACT_CREATE, 63);
		play(ACT_CREATE, 64);
		// top orbitals packed, so the move comes from further down
		play(ACT_NEXT, 64);
		play(ACT_DESTROY, 1);
		play(ACT_NEXT, 1);

		// shrink the basis under a set that no longer fits: next must give up
		write_basis(2);
		play(ACT_NEXT, 2);
		play(ACT_CREATE, 3);
		play(ACT_DESTROY, 2);
		play(ACT_DESTROY, 34);

		// random phases over several basis sizes, 1 and 64 among them;
		// a zero in the plan means a random size
		for (p = 0; p < 10; p++) begin
			clear_string();
			write_basis((plan[p] == 0) ? $urandom_range(1, MAX_ORBITALS) : plan[p]);
			steady = (p == 3);
			run_phase(PHASE_ITEMS);
		end
		steady = 1'b0;

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("[fermion_occupation_string_top] OK");
		else
			$display("[fermion_occupation_string_top] ERROR");
		$finish;
	end

endmodule
